>>> rtl/core/usb_endpoint_number_allocator_unit_macros.svh
// ----------------------------------------------------------------------------
// usb endpoint number allocator assertion macros
// shared property templates for the allocator rtl
// ----------------------------------------------------------------------------
`ifndef USB_ENDPOINT_NUMBER_ALLOCATOR_UNIT_MACROS_SVH
`define USB_ENDPOINT_NUMBER_ALLOCATOR_UNIT_MACROS_SVH

// same-cycle implication
`define USB_ENA_ASSERT_IMPLIES(label, clk, rst_n, cond, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (prop)) \
        else $error("usb_ena: same-cycle check failed");

// next-cycle implication
`define USB_ENA_ASSERT_NEXT(label, clk, rst_n, cond, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (prop)) \
        else $error("usb_ena: next-cycle check failed");

`endif

>>> rtl/core/usb_ena_pkg.sv
// ----------------------------------------------------------------------------
// usb endpoint number allocator package
// request and result word types, operation and error codes, register indexes
// ----------------------------------------------------------------------------
package usb_ena_pkg;

    typedef enum logic [2:0] {
        MODE_ALLOC_IN     = 3'd0,
        MODE_ALLOC_OUT    = 3'd1,
        MODE_ALLOC_DUPLEX = 3'd2,
        MODE_RESERVE      = 3'd3,
        MODE_ALLOC_IFACE  = 3'd4,
        MODE_ALLOC_STRING = 3'd5
    } mode_t;

    typedef enum logic [2:0] {
        ERR_NONE        = 3'd0,
        ERR_INVALID     = 3'd1,
        ERR_IFACE_OVF   = 3'd2,
        ERR_STRING_OVF  = 3'd3,
        ERR_EP_OVF      = 3'd4,
        ERR_EP_CONFLICT = 3'd5
    } err_t;

    typedef enum logic [1:0] {
        CFG_MAX_EP_NUMBER = 2'd0,
        CFG_MAX_IN_EPS    = 2'd1,
        CFG_MAX_OUT_EPS   = 2'd2,
        CFG_FIRST_STRING  = 2'd3
    } cfg_index_t;

    localparam int CFG_DATA_W = 8;
    localparam int EP_NUM_W   = 4;

    localparam logic [EP_NUM_W-1:0]   MAX_EP_NUMBER_RST = 4'd15;
    localparam logic [EP_NUM_W-1:0]   MAX_IN_EPS_RST    = 4'd15;
    localparam logic [EP_NUM_W-1:0]   MAX_OUT_EPS_RST   = 4'd15;
    localparam logic [7:0]            FIRST_STRING_RST  = 8'd1;
    localparam logic [7:0]            IN_DIR_FLAG       = 8'h80;
    localparam logic [7:0]            IFACE_FAIL_VALUE  = 8'hff;

    // first field in the highest bits
    typedef struct packed {
        mode_t      mode;
        logic [7:0] interface_count;
        logic [7:0] endpoint_address;
    } request_t;

    typedef struct packed {
        err_t       error_code;
        logic [7:0] duplex_in_address;
        logic [7:0] result_value;
        logic       success;
    } result_t;

endpackage

>>> rtl/core/usb_ena_stage.sv
// ----------------------------------------------------------------------------
// usb endpoint allocator register stage
// one-word pipeline register with valid/ready flow control
// ----------------------------------------------------------------------------
module usb_ena_stage #(
    parameter int WIDTH = 8
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    output logic             in_ready,
    input  logic [WIDTH-1:0] in_data,
    output logic             out_valid,
    input  logic             out_ready,
    output logic [WIDTH-1:0] out_data
);

    logic             valid_reg;
    logic [WIDTH-1:0] data_reg;

    assign in_ready  = !valid_reg || out_ready;
    assign out_valid = valid_reg;
    assign out_data  = data_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            valid_reg <= in_valid;
        end
    end

    // payload needs no reset
    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            data_reg <= in_data;
        end
    end

endmodule

>>> rtl/core/usb_ena_core.sv
// ----------------------------------------------------------------------------
// usb endpoint allocator decision core
// limit registers, endpoint bitmaps, counters, sticky error and request logic
// ----------------------------------------------------------------------------
`include "usb_endpoint_number_allocator_unit_macros.svh"

module usb_ena_core #(
    parameter int ENDPOINT_SLOTS = 15
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_we,
    input  logic [1:0]                        cfg_index,
    input  logic [usb_ena_pkg::CFG_DATA_W-1:0] cfg_data,
    input  usb_ena_pkg::request_t             req,
    input  logic                              req_fire,
    output usb_ena_pkg::result_t              res
);

    localparam int MW = ENDPOINT_SLOTS + 1;
    localparam int PW = $clog2(MW + 1);
    localparam int NW = usb_ena_pkg::EP_NUM_W;
    localparam logic [NW-1:0] SLOTS_LIMIT = NW'(ENDPOINT_SLOTS);
    localparam logic [MW-1:0] ONE_BIT = {{(MW-1){1'b0}}, 1'b1};

    logic [NW-1:0]         max_ep_reg;
    logic [NW-1:0]         max_in_reg;
    logic [NW-1:0]         max_out_reg;
    logic [7:0]            first_str_reg;

    logic [MW-1:0]         in_mask_reg;
    logic [MW-1:0]         in_mask_next;
    logic [MW-1:0]         out_mask_reg;
    logic [MW-1:0]         out_mask_next;
    logic [7:0]            iface_reg;
    logic [7:0]            iface_next;
    logic [8:0]            strings_reg;
    logic [8:0]            strings_next;
    usb_ena_pkg::err_t     sticky_reg;
    usb_ena_pkg::err_t     sticky_next;

    usb_ena_pkg::err_t     err_pre;
    logic                  limits_bad;
    logic                  room_in;
    logic                  room_out;
    logic [NW-1:0]         free_in;
    logic [NW-1:0]         free_out;
    logic [NW-1:0]         free_both;
    logic                  dir_in;
    logic                  room_dir;
    logic [NW-1:0]         free_dir;
    logic [NW-1:0]         rsv_num;
    logic                  rsv_dir_in;
    logic                  rsv_room;
    logic [MW-1:0]         rsv_bit;
    logic                  rsv_conflict;
    logic [MW-1:0]         free_bit;
    logic [8:0]            iface_sum;
    logic [9:0]            str_next;

    function automatic logic [PW-1:0] bit_count(input logic [MW-1:0] v);
        logic [PW-1:0] c;
        c = '0;
        for (int i = 0; i < MW; i++)
        begin
            c = c + PW'(v[i]);
        end
        return c;
    endfunction

    function automatic logic [NW-1:0] lowest_free(input logic [MW-1:0] used,
                                                  input logic [NW-1:0] lim);
        logic [NW-1:0] n;
        logic          found;
        n     = '0;
        found = 1'b0;
        for (int i = 1; i < MW; i++)
        begin
            if (!found && (NW'(i) <= lim) && !used[i])
            begin
                n     = NW'(i);
                found = 1'b1;
            end
        end
        return n;
    endfunction

    // limit checks and searches
    assign limits_bad = (max_ep_reg == '0) || (max_ep_reg > SLOTS_LIMIT) ||
                        (max_in_reg > max_ep_reg) || (max_out_reg > max_ep_reg);
    assign err_pre = ((sticky_reg == usb_ena_pkg::ERR_NONE) && limits_bad)
                     ? usb_ena_pkg::ERR_INVALID : sticky_reg;

    assign room_in  = (PW + NW)'(bit_count(in_mask_reg)) < (PW + NW)'(max_in_reg);
    assign room_out = (PW + NW)'(bit_count(out_mask_reg)) < (PW + NW)'(max_out_reg);
    assign free_in   = lowest_free(in_mask_reg, max_ep_reg);
    assign free_out  = lowest_free(out_mask_reg, max_ep_reg);
    assign free_both = lowest_free(in_mask_reg | out_mask_reg, max_ep_reg);

    assign dir_in   = (req.mode == usb_ena_pkg::MODE_ALLOC_IN);
    assign room_dir = dir_in ? room_in : room_out;
    assign free_dir = dir_in ? free_in : free_out;

    assign rsv_num      = req.endpoint_address[NW-1:0];
    assign rsv_dir_in   = req.endpoint_address[7];
    assign rsv_room     = rsv_dir_in ? room_in : room_out;
    assign rsv_bit      = ONE_BIT << rsv_num;
    assign rsv_conflict = |((rsv_dir_in ? in_mask_reg : out_mask_reg) & rsv_bit);

    assign iface_sum = {1'b0, iface_reg} + {1'b0, req.interface_count};
    assign str_next  = 10'(first_str_reg) + 10'(strings_reg);

    always_comb
    begin
        free_bit         = '0;
        in_mask_next     = in_mask_reg;
        out_mask_next    = out_mask_reg;
        iface_next       = iface_reg;
        strings_next     = strings_reg;
        sticky_next      = err_pre;
        res.success           = 1'b0;
        res.result_value      = '0;
        res.duplex_in_address = '0;
        case (req.mode)
            usb_ena_pkg::MODE_ALLOC_IN,
            usb_ena_pkg::MODE_ALLOC_OUT:
            begin
                free_bit = ONE_BIT << free_dir;
                if (err_pre == usb_ena_pkg::ERR_NONE)
                begin
                    if (!room_dir || (free_dir == '0))
                    begin
                        sticky_next = usb_ena_pkg::ERR_EP_OVF;
                    end
                    else
                    begin
                        res.success = 1'b1;
                        if (dir_in)
                        begin
                            in_mask_next     = in_mask_reg | free_bit;
                            res.result_value = usb_ena_pkg::IN_DIR_FLAG | 8'(free_dir);
                        end
                        else
                        begin
                            out_mask_next    = out_mask_reg | free_bit;
                            res.result_value = 8'(free_dir);
                        end
                    end
                end
            end
            usb_ena_pkg::MODE_ALLOC_DUPLEX:
            begin
                free_bit = ONE_BIT << free_both;
                if (err_pre == usb_ena_pkg::ERR_NONE)
                begin
                    if (!room_in || !room_out || (free_both == '0))
                    begin
                        sticky_next = usb_ena_pkg::ERR_EP_OVF;
                    end
                    else
                    begin
                        res.success           = 1'b1;
                        res.result_value      = 8'(free_both);
                        res.duplex_in_address = usb_ena_pkg::IN_DIR_FLAG | 8'(free_both);
                        in_mask_next          = in_mask_reg | free_bit;
                        out_mask_next         = out_mask_reg | free_bit;
                    end
                end
            end
            usb_ena_pkg::MODE_RESERVE:
            begin
                if (err_pre == usb_ena_pkg::ERR_NONE)
                begin
                    if (req.endpoint_address[6:4] != 3'd0)
                    begin
                        sticky_next = usb_ena_pkg::ERR_INVALID;
                    end
                    else if ((rsv_num == '0) || (rsv_num > max_ep_reg))
                    begin
                        sticky_next = usb_ena_pkg::ERR_INVALID;
                    end
                    else if (!rsv_room)
                    begin
                        sticky_next = usb_ena_pkg::ERR_EP_OVF;
                    end
                    else if (rsv_conflict)
                    begin
                        sticky_next = usb_ena_pkg::ERR_EP_CONFLICT;
                    end
                    else
                    begin
                        res.success      = 1'b1;
                        res.result_value = req.endpoint_address;
                        if (rsv_dir_in)
                        begin
                            in_mask_next = in_mask_reg | rsv_bit;
                        end
                        else
                        begin
                            out_mask_next = out_mask_reg | rsv_bit;
                        end
                    end
                end
            end
            usb_ena_pkg::MODE_ALLOC_IFACE:
            begin
                res.result_value = usb_ena_pkg::IFACE_FAIL_VALUE;
                if (err_pre == usb_ena_pkg::ERR_NONE)
                begin
                    if (req.interface_count == 8'd0)
                    begin
                        sticky_next = usb_ena_pkg::ERR_INVALID;
                    end
                    else if (iface_sum[8])
                    begin
                        sticky_next = usb_ena_pkg::ERR_IFACE_OVF;
                    end
                    else
                    begin
                        res.success      = 1'b1;
                        res.result_value = iface_reg;
                        iface_next       = iface_sum[7:0];
                    end
                end
            end
            usb_ena_pkg::MODE_ALLOC_STRING:
            begin
                if (err_pre == usb_ena_pkg::ERR_NONE)
                begin
                    if (str_next[9:8] != 2'd0)
                    begin
                        sticky_next = usb_ena_pkg::ERR_STRING_OVF;
                    end
                    else
                    begin
                        res.success      = 1'b1;
                        res.result_value = str_next[7:0];
                        strings_next     = strings_reg + 9'd1;
                    end
                end
            end
            default:
            begin
                sticky_next = err_pre;
            end
        endcase
        res.error_code = sticky_next;
    end

    // limit registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_ep_reg    <= usb_ena_pkg::MAX_EP_NUMBER_RST;
            max_in_reg    <= usb_ena_pkg::MAX_IN_EPS_RST;
            max_out_reg   <= usb_ena_pkg::MAX_OUT_EPS_RST;
            first_str_reg <= usb_ena_pkg::FIRST_STRING_RST;
        end
        else if (cfg_we)
        begin
            case (usb_ena_pkg::cfg_index_t'(cfg_index))
                usb_ena_pkg::CFG_MAX_EP_NUMBER: max_ep_reg    <= cfg_data[NW-1:0];
                usb_ena_pkg::CFG_MAX_IN_EPS:    max_in_reg    <= cfg_data[NW-1:0];
                usb_ena_pkg::CFG_MAX_OUT_EPS:   max_out_reg   <= cfg_data[NW-1:0];
                usb_ena_pkg::CFG_FIRST_STRING:  first_str_reg <= cfg_data;
                default:                        max_ep_reg    <= max_ep_reg;
            endcase
        end
    end

    // allocation state, updated as each word leaves the input stage
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_mask_reg  <= '0;
            out_mask_reg <= '0;
            iface_reg    <= '0;
            strings_reg  <= '0;
            sticky_reg   <= usb_ena_pkg::ERR_NONE;
        end
        else if (req_fire)
        begin
            in_mask_reg  <= in_mask_next;
            out_mask_reg <= out_mask_next;
            iface_reg    <= iface_next;
            strings_reg  <= strings_next;
            sticky_reg   <= sticky_next;
        end
    end

    `USB_ENA_ASSERT_NEXT(a_sticky_holds, clk, rst_n,
        sticky_reg != usb_ena_pkg::ERR_NONE, sticky_reg != usb_ena_pkg::ERR_NONE)
    `USB_ENA_ASSERT_IMPLIES(a_success_no_error, clk, rst_n,
        res.success, res.error_code == usb_ena_pkg::ERR_NONE)
    `USB_ENA_ASSERT_NEXT(a_masks_idle, clk, rst_n,
        !req_fire, $stable(in_mask_reg) && $stable(out_mask_reg))
    `USB_ENA_ASSERT_NEXT(a_in_mask_grows, clk, rst_n,
        req_fire, (in_mask_reg & $past(in_mask_reg)) == $past(in_mask_reg))
    `USB_ENA_ASSERT_NEXT(a_error_blocks, clk, rst_n,
        req_fire && (sticky_reg != usb_ena_pkg::ERR_NONE),
        $stable(in_mask_reg) && $stable(iface_reg) && $stable(strings_reg))

endmodule

>>> rtl/core/usb_endpoint_number_allocator_unit.sv
// datapath: an accepted word is held in the input register, decided by the
//   combinational core, then registered in the result register at the output
// throughput: one request per cycle while m_tready is high, set by the single
//   decision stage between the input register and the result register
// reset: asynchronous, clears bitmaps, counters and sticky error, and loads
//   the limit registers with their defaults
// ----------------------------------------------------------------------------
// usb endpoint number allocator
// bitmap first-fit endpoint, interface and string index allocator
// ----------------------------------------------------------------------------
module usb_endpoint_number_allocator_unit #(
    parameter int ENDPOINT_SLOTS = 15
) (
    input  logic        clk,
    input  logic        rst_n,
    // configuration writes
    input  logic        cfg_we,
    input  logic [1:0]  cfg_index,
    input  logic [7:0]  cfg_data,
    // request words
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [15:0] s_tdata,  // endpoint_address[7:0], interface_count[15:8]
    input  logic [2:0]  s_tuser,  // mode[2:0]
    // result words
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata   // success[0], result_value[8:1],
                                  // duplex_in_address[16:9], error_code[19:17]
);

    localparam int REQ_W = $bits(usb_ena_pkg::request_t);
    localparam int RES_W = $bits(usb_ena_pkg::result_t);

    logic                  req_valid;
    logic                  res_ready;
    logic [REQ_W-1:0]      req_bits;
    logic [RES_W-1:0]      res_bits;
    usb_ena_pkg::request_t req;
    usb_ena_pkg::result_t  res;

    assign req = usb_ena_pkg::request_t'(req_bits);

    usb_ena_stage #(
        .WIDTH (REQ_W)
    ) u_in_stage (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .in_data   ({s_tuser, s_tdata[15:8], s_tdata[7:0]}),
        .out_valid (req_valid),
        .out_ready (res_ready),
        .out_data  (req_bits)
    );

    usb_ena_core #(
        .ENDPOINT_SLOTS (ENDPOINT_SLOTS)
    ) u_core (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .req       (req),
        .req_fire  (req_valid && res_ready),
        .res       (res)
    );

    usb_ena_stage #(
        .WIDTH (RES_W)
    ) u_out_stage (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (req_valid),
        .in_ready  (res_ready),
        .in_data   (res),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_data  (res_bits)
    );

    assign m_tdata = {4'b0, res_bits};

endmodule
